// ===== rtl/core/tsfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_pkg
// Shared constants, types and helpers of the two-stage frequency protection.
// ----------------------------------------------------------------------------
package tsfp_pkg;

	localparam int unsigned FREQ_W  = 16;
	localparam int unsigned DLY_W   = 16;
	localparam int unsigned TMR_W   = 21;
	localparam int unsigned N_TMR   = 4;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned RIDX_W  = 3;
	localparam int unsigned UNIT_MS = 20;
	localparam int unsigned MIN_MS  = 10;

	// timer indexes
	localparam int unsigned T_OV1 = 0;
	localparam int unsigned T_OV2 = 1;
	localparam int unsigned T_UN1 = 2;
	localparam int unsigned T_UN2 = 3;

	// register indexes
	localparam logic [RIDX_W-1:0] REG_OVER_THR_ONE   = 3'd0;
	localparam logic [RIDX_W-1:0] REG_OVER_THR_TWO   = 3'd1;
	localparam logic [RIDX_W-1:0] REG_UNDER_THR_ONE  = 3'd2;
	localparam logic [RIDX_W-1:0] REG_UNDER_THR_TWO  = 3'd3;
	localparam logic [RIDX_W-1:0] REG_OVER_DLY_ONE   = 3'd4;
	localparam logic [RIDX_W-1:0] REG_OVER_DLY_TWO   = 3'd5;
	localparam logic [RIDX_W-1:0] REG_UNDER_DLY_ONE  = 3'd6;
	localparam logic [RIDX_W-1:0] REG_UNDER_DLY_TWO  = 3'd7;

	// request kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef struct packed {
		logic tick;
		logic start;
		logic stop;
	} tmr_ctl_t;

	typedef struct packed {
		logic [N_TMR-1:0] expired_mask;
		logic [N_TMR-1:0] running_mask;
		logic             trip;
		logic             fault;
	} result_t;

	function automatic logic [TMR_W-1:0] tmr_load(input logic [DLY_W-1:0] dly);
		logic [TMR_W-1:0] ms;
		ms = TMR_W'(dly) * TMR_W'(UNIT_MS);
		return (dly == '0) ? TMR_W'(MIN_MS) : ms;
	endfunction

endpackage

// ===== rtl/core/tsfp_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_timer
// One-shot millisecond delay timer; a start is ignored while it runs.
// ----------------------------------------------------------------------------
module tsfp_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsfp_pkg::tmr_ctl_t            ctl,
	input  logic                          flush,
	input  logic [tsfp_pkg::TMR_W-1:0]    load,
	output logic                          running,
	output logic                          running_nx,
	output logic                          expired
);
	import tsfp_pkg::*;

	logic [TMR_W-1:0] left_q;
	logic [TMR_W-1:0] left_dec;
	logic [TMR_W-1:0] left_nx;
	logic             run_q;

	always_comb begin
		left_dec   = left_q - TMR_W'(left_q != '0);
		expired    = ctl.tick && run_q && (left_dec == '0);
		running_nx = run_q;
		left_nx    = left_q;
		if (ctl.stop || flush) begin
			running_nx = 1'b0;
			left_nx    = '0;
		end else if (ctl.tick && run_q) begin
			left_nx = left_dec;
		end else if (ctl.start && !run_q) begin
			running_nx = 1'b1;
			left_nx    = load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			left_q <= '0;
		end else begin
			run_q  <= running_nx;
			left_q <= left_nx;
		end
	end

	assign running = run_q;

`ifndef SYNTHESIS
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> left_q != '0)
		else $error("running timer with zero count");
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.stop || flush) |=> !run_q && left_q == '0)
		else $error("stopped timer not cleared");
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.start && !run_q && !ctl.stop && !flush && !ctl.tick) |=> run_q)
		else $error("start on idle timer lost");
`endif

endmodule

// ===== rtl/core/two_stage_frequency_protection_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stage_frequency_protection_top
// Two-stage over/under-frequency trip with four one-shot delay timers.
// ----------------------------------------------------------------------------
// Each request is either a frequency sample (tuser 0, tdata in 0.01 Hz) or a
// 1 ms tick (tuser 1) and yields exactly one result. A request is registered,
// then evaluated combinationally against the thresholds and the four timers
// and written to the result register, so one request is taken every clock;
// only a stalled result register holds the input back. Thresholds and delays
// sit on the APB port at byte address 4*index; the user must write them only
// while no request is in flight, as the block itself does not enforce this.
module two_stage_frequency_protection_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsfp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // freq_centihz
	input  logic                          s_axis_tuser,  // kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// fault, trip, running_mask[3:0], expired_mask[3:0], zero pad
	output logic [15:0]                   m_axis_tdata
);
	import tsfp_pkg::*;

	// configuration
	logic [FREQ_W-1:0] over_one_q, over_two_q, under_one_q, under_two_q;
	logic [DLY_W-1:0]  dly_q [N_TMR];
	logic [RIDX_W-1:0] ridx;
	logic              wr_en;

	// pipeline
	logic              vld_s1, vld_s2, adv;
	logic              kind_s1;
	logic [FREQ_W-1:0] freq_s1;
	result_t           res_s2, res_nx;

	// protection state
	logic              over_flag_q, under_flag_q, fault_q;
	logic              over_flag_nx, under_flag_nx;

	// sample evaluation
	logic              up_is_one, down_is_one, in_band;
	logic [FREQ_W-1:0] up, down, o_tf, u_tf;
	logic              over_act, under_act, o_set, o_clr, u_set, u_clr;
	logic              smp, tck, flush;
	logic [N_TMR-1:0]  start, stop, running, running_nx, expired;
	tmr_ctl_t          ctl [N_TMR];

	assign pready = 1'b1;
	assign ridx   = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_one_q  <= '0;
			over_two_q  <= '0;
			under_one_q <= '0;
			under_two_q <= '0;
			for (int i = 0; i < N_TMR; i++) begin
				dly_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (ridx)
				REG_OVER_THR_ONE:  over_one_q     <= pwdata[FREQ_W-1:0];
				REG_OVER_THR_TWO:  over_two_q     <= pwdata[FREQ_W-1:0];
				REG_UNDER_THR_ONE: under_one_q    <= pwdata[FREQ_W-1:0];
				REG_UNDER_THR_TWO: under_two_q    <= pwdata[FREQ_W-1:0];
				REG_OVER_DLY_ONE:  dly_q[T_OV1]   <= pwdata[DLY_W-1:0];
				REG_OVER_DLY_TWO:  dly_q[T_OV2]   <= pwdata[DLY_W-1:0];
				REG_UNDER_DLY_ONE: dly_q[T_UN1]   <= pwdata[DLY_W-1:0];
				REG_UNDER_DLY_TWO: dly_q[T_UN2]   <= pwdata[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_OVER_THR_ONE:  prdata = 32'(over_one_q);
			REG_OVER_THR_TWO:  prdata = 32'(over_two_q);
			REG_UNDER_THR_ONE: prdata = 32'(under_one_q);
			REG_UNDER_THR_TWO: prdata = 32'(under_two_q);
			REG_OVER_DLY_ONE:  prdata = 32'(dly_q[T_OV1]);
			REG_OVER_DLY_TWO:  prdata = 32'(dly_q[T_OV2]);
			REG_UNDER_DLY_ONE: prdata = 32'(dly_q[T_UN1]);
			REG_UNDER_DLY_TWO: prdata = 32'(dly_q[T_UN2]);
			default:           prdata = '0;
		endcase
	end

	// handshake
	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			freq_s1 <= s_axis_tdata;
		end
		if (adv) begin
			res_s2 <= res_nx;
		end
	end

	// band and stage decisions
	always_comb begin
		smp = adv && (kind_s1 == KIND_SAMPLE);
		tck = adv && (kind_s1 == KIND_TICK);

		up_is_one   = !(over_one_q > over_two_q);
		up          = up_is_one ? over_one_q : over_two_q;
		o_tf        = up_is_one ? over_two_q : over_one_q;
		down_is_one = !(under_one_q < under_two_q);
		down        = down_is_one ? under_one_q : under_two_q;
		u_tf        = down_is_one ? under_two_q : under_one_q;

		in_band   = (freq_s1 >= down) && (freq_s1 <= up);
		over_act  = smp && !in_band && (freq_s1 > up);
		under_act = smp && !in_band && (freq_s1 < down);

		o_set = over_act && (freq_s1 > o_tf);
		o_clr = over_act && !o_set && over_flag_q;
		u_set = under_act && (freq_s1 < u_tf);
		u_clr = under_act && !u_set && under_flag_q;

		start = '0;
		stop  = '0;
		if (up_is_one) begin
			start[T_OV1] = over_act;
			start[T_OV2] = o_set;
			stop[T_OV2]  = o_clr;
		end else begin
			start[T_OV2] = over_act;
			start[T_OV1] = o_set;
			stop[T_OV1]  = o_clr;
		end
		if (down_is_one) begin
			start[T_UN1] = under_act;
			start[T_UN2] = u_set;
			stop[T_UN2]  = u_clr;
		end else begin
			start[T_UN2] = under_act;
			start[T_UN1] = u_set;
			stop[T_UN1]  = u_clr;
		end
		if (smp && in_band) begin
			stop = '1;
		end

		over_flag_nx  = o_set ? 1'b1 : (o_clr ? 1'b0 : over_flag_q);
		under_flag_nx = u_set ? 1'b1 : (u_clr ? 1'b0 : under_flag_q);
	end

	assign flush = |expired;

	for (genvar g = 0; g < N_TMR; g++) begin : g_tmr
		assign ctl[g] = '{tick: tck, start: start[g], stop: stop[g]};
		tsfp_timer u_tmr (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[g]),
			.flush      (flush),
			.load       (tmr_load(dly_q[g])),
			.running    (running[g]),
			.running_nx (running_nx[g]),
			.expired    (expired[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_flag_q  <= 1'b0;
			under_flag_q <= 1'b0;
			fault_q      <= 1'b0;
		end else begin
			over_flag_q  <= over_flag_nx;
			under_flag_q <= under_flag_nx;
			if (flush) begin
				fault_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res_nx.fault        = fault_q || flush;
		res_nx.trip         = flush;
		res_nx.running_mask = running_nx;
		res_nx.expired_mask = expired;
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = 16'(res_s2);

`ifndef SYNTHESIS
	a_expiry_stops_all: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> running == '0)
		else $error("timers still running after expiry");
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault latch cleared");
	a_sample_no_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		smp |=> res_s2.expired_mask == '0 && !res_s2.trip)
		else $error("expiry reported on a sample");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> vld_s1)
		else $error("pending request dropped");
`endif

endmodule

// ===== bench/trip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trip_checker
// Watches the request, result and register ports of the frequency protection.
// Keeps its own copy of the thresholds, delays, timers and stage flags and works
// out the result of every accepted request. Each accepted result is compared
// field by field with the oldest outstanding prediction. Register reads are
// checked against the register copy. Failures are counted for the top level.
// ----------------------------------------------------------------------------
module trip_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // freq_centihz
	input  logic                        s_axis_tuser,  // kind
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// fault, trip, running_mask[3:0], expired_mask[3:0], zero pad
	input  logic [15:0]                 m_axis_tdata,
	output int unsigned                 mismatch_count,
	output int unsigned                 pending_count
);

	import tsfp_pkg::*;

	logic [15:0]      cfg_regs [8];
	logic [TMR_W-1:0] left_ms [N_TMR];
	logic [N_TMR-1:0] run_bits;
	logic             over_armed;
	logic             under_armed;
	logic             fault_seen;

	result_t          outcome_q [$];
	result_t          got;
	result_t          want;
	logic [N_TMR-1:0] fired;
	int unsigned      result_index;

	task automatic flag_mismatch(input string what);
		if (mismatch_count < 10)
			$display("mismatch: %s", what);
		mismatch_count++;
	endtask

	task automatic halt_timer(input int n);
		run_bits[n] = 1'b0;
		left_ms[n]  = '0;
	endtask

	task automatic halt_all();
		for (int i = 0; i < N_TMR; i++)
			halt_timer(i);
	endtask

	task automatic arm_timer(input int n);
		logic [15:0] dly;
		// delay registers follow timer order
		dly = cfg_regs[int'(REG_OVER_DLY_ONE) + n];
		if (!run_bits[n]) begin
			run_bits[n] = 1'b1;
			left_ms[n]  = (dly == '0) ? TMR_W'(MIN_MS) : TMR_W'(dly) * TMR_W'(UNIT_MS);
		end
	endtask

	task automatic apply_sample(input logic [15:0] f);
		logic        up_one;
		logic        down_one;
		logic [15:0] up;
		logic [15:0] down;
		logic [15:0] far_thr;
		int          near_t;
		int          far_t;
		up_one   = !(cfg_regs[REG_OVER_THR_ONE] > cfg_regs[REG_OVER_THR_TWO]);
		up       = up_one ? cfg_regs[REG_OVER_THR_ONE] : cfg_regs[REG_OVER_THR_TWO];
		down_one = !(cfg_regs[REG_UNDER_THR_ONE] < cfg_regs[REG_UNDER_THR_TWO]);
		down     = down_one ? cfg_regs[REG_UNDER_THR_ONE] : cfg_regs[REG_UNDER_THR_TWO];
		if (f >= down && f <= up) begin
			halt_all();
			return;
		end
		if (f > up) begin
			near_t  = up_one ? T_OV1 : T_OV2;
			far_t   = up_one ? T_OV2 : T_OV1;
			far_thr = up_one ? cfg_regs[REG_OVER_THR_TWO] : cfg_regs[REG_OVER_THR_ONE];
			arm_timer(near_t);
			if (f > far_thr) begin
				over_armed = 1'b1;
				arm_timer(far_t);
			end
			if (f <= far_thr && over_armed) begin
				over_armed = 1'b0;
				halt_timer(far_t);
			end
		end
		if (f < down) begin
			near_t  = down_one ? T_UN1 : T_UN2;
			far_t   = down_one ? T_UN2 : T_UN1;
			far_thr = down_one ? cfg_regs[REG_UNDER_THR_TWO] : cfg_regs[REG_UNDER_THR_ONE];
			arm_timer(near_t);
			if (f < far_thr) begin
				under_armed = 1'b1;
				arm_timer(far_t);
			end
			if (f >= far_thr && under_armed) begin
				under_armed = 1'b0;
				halt_timer(far_t);
			end
		end
	endtask

	task automatic apply_tick(output logic [N_TMR-1:0] expired);
		expired = '0;
		for (int i = 0; i < N_TMR; i++) begin
			if (run_bits[i]) begin
				if (left_ms[i] != '0)
					left_ms[i]--;
				if (left_ms[i] == '0)
					expired[i] = 1'b1;
			end
		end
		if (expired != '0) begin
			fault_seen = 1'b1;
			halt_all();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcome_q.delete();
			for (int i = 0; i < 8; i++)
				cfg_regs[i] = '0;
			for (int i = 0; i < N_TMR; i++)
				left_ms[i] = '0;
			run_bits       = '0;
			over_armed     = 1'b0;
			under_armed    = 1'b0;
			fault_seen     = 1'b0;
			mismatch_count = 0;
			pending_count  = 0;
			result_index   = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (outcome_q.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with no request outstanding",
						result_index));
				end else begin
					want = outcome_q.pop_front();
					if (got.fault !== want.fault || got.trip !== want.trip ||
					    got.running_mask !== want.running_mask ||
					    got.expired_mask !== want.expired_mask)
						flag_mismatch($sformatf({"result %0d: expected fault %0b trip %0b ",
							"running %b expired %b, got fault %0b trip %0b running %b ",
							"expired %b"}, result_index, want.fault, want.trip,
							want.running_mask, want.expired_mask, got.fault, got.trip,
							got.running_mask, got.expired_mask));
				end
				result_index++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fired = '0;
				if (s_axis_tuser == KIND_TICK)
					apply_tick(fired);
				else
					apply_sample(s_axis_tdata);
				want.fault        = fault_seen;
				want.trip         = (fired != '0);
				want.running_mask = run_bits;
				want.expired_mask = fired;
				outcome_q.push_back(want);
			end
			if (psel && penable && pready) begin
				if (pwrite)
					cfg_regs[paddr[ADDR_W-1:2]] = pwdata[15:0];
				else if (prdata !== {16'd0, cfg_regs[paddr[ADDR_W-1:2]]})
					flag_mismatch($sformatf("read of register %0d: expected %h, got %h",
						paddr[ADDR_W-1:2], {16'd0, cfg_regs[paddr[ADDR_W-1:2]]}, prdata));
			end
			pending_count = outcome_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-stage frequency protection.
// A short directed run covers tied thresholds, simultaneous expiry, stage flag
// set and clear and the sticky fault. Then random phases each load a new set of
// thresholds and delays over the register port and send episodes of samples
// hovering around a threshold followed by runs of millisecond ticks, with some
// noise. Requests come in bursts with gaps, results are taken with stalls.
// ----------------------------------------------------------------------------
module tb_top;

	import tsfp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEM_GOAL   = 1630;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [15:0]        s_axis_tdata;
	logic               s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [15:0]        m_axis_tdata;

	int unsigned        mismatch_count;
	int unsigned        pending_count;
	int unsigned        cycle_count = 0;
	int unsigned        items_sent  = 0;
	int unsigned        burst_left;
	int unsigned        stall_mode;
	int unsigned        stall_span  = 0;
	int unsigned        phase_goal;
	logic [15:0]        thr_now [4];

	two_stage_frequency_protection_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	trip_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// result side stalls on a pattern of its own
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(20, 200);
			end
			stall_span--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				2: m_axis_tready <= (stall_span % 5 != 0);
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic send_request(input logic kind, input logic [15:0] freq);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= freq;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_ticks(input int unsigned count);
		repeat (count)
			send_request(KIND_TICK, 16'($urandom));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [RIDX_W-1:0] idx,
	                          input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		// upper bits are outside the register and must be dropped
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] o1, input logic [15:0] o2,
	                             input logic [15:0] u1, input logic [15:0] u2,
	                             input logic [15:0] d0, input logic [15:0] d1,
	                             input logic [15:0] d2, input logic [15:0] d3);
		thr_now[0] = o1;
		thr_now[1] = o2;
		thr_now[2] = u1;
		thr_now[3] = u2;
		apb_access(1'b1, REG_OVER_THR_ONE, o1);
		apb_access(1'b1, REG_OVER_THR_TWO, o2);
		apb_access(1'b1, REG_UNDER_THR_ONE, u1);
		apb_access(1'b1, REG_UNDER_THR_TWO, u2);
		apb_access(1'b1, REG_OVER_DLY_ONE, d0);
		apb_access(1'b1, REG_OVER_DLY_TWO, d1);
		apb_access(1'b1, REG_UNDER_DLY_ONE, d2);
		apb_access(1'b1, REG_UNDER_DLY_TWO, d3);
		apb_access(1'b0, REG_OVER_THR_ONE, '0);
		apb_access(1'b0, REG_OVER_THR_TWO, '0);
		apb_access(1'b0, REG_UNDER_THR_ONE, '0);
		apb_access(1'b0, REG_UNDER_THR_TWO, '0);
		apb_access(1'b0, REG_OVER_DLY_ONE, '0);
		apb_access(1'b0, REG_OVER_DLY_TWO, '0);
		apb_access(1'b0, REG_UNDER_DLY_ONE, '0);
		apb_access(1'b0, REG_UNDER_DLY_TWO, '0);
	endtask

	function automatic logic [15:0] pick_delay();
		case ($urandom_range(0, 15))
			0: return 16'hFFFF;
			1, 2: return 16'($urandom_range(3, 10));
			default: return 16'($urandom_range(0, 2));
		endcase
	endfunction

	function automatic logic [15:0] pick_extreme(input logic [15:0] c);
		case ($urandom_range(0, 2))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return c;
		endcase
	endfunction

	task automatic random_settings();
		logic [15:0] c;
		logic [15:0] o1;
		logic [15:0] o2;
		logic [15:0] u1;
		logic [15:0] u2;
		c = 16'($urandom_range(2000, 63000));
		case ($urandom_range(0, 4))
			0: begin
				// normal ordering, stage one nearer
				o1 = c + 16'($urandom_range(1, 300));
				o2 = o1 + 16'($urandom_range(1, 300));
				u1 = c - 16'($urandom_range(1, 300));
				u2 = u1 - 16'($urandom_range(1, 300));
			end
			1: begin
				// stage two nearer on both sides
				o2 = c + 16'($urandom_range(1, 300));
				o1 = o2 + 16'($urandom_range(1, 300));
				u2 = c - 16'($urandom_range(1, 300));
				u1 = u2 - 16'($urandom_range(1, 300));
			end
			2: begin
				o1 = c + 16'($urandom_range(0, 300));
				o2 = o1;
				u1 = c - 16'($urandom_range(0, 300));
				u2 = u1;
			end
			3: begin
				// any order, empty band likely
				o1 = c + 16'($urandom_range(0, 600)) - 16'd300;
				o2 = c + 16'($urandom_range(0, 600)) - 16'd300;
				u1 = c + 16'($urandom_range(0, 600)) - 16'd300;
				u2 = c + 16'($urandom_range(0, 600)) - 16'd300;
			end
			default: begin
				o1 = pick_extreme(c);
				o2 = pick_extreme(c);
				u1 = pick_extreme(c);
				u2 = pick_extreme(c);
			end
		endcase
		load_settings(o1, o2, u1, u2, pick_delay(), pick_delay(), pick_delay(), pick_delay());
	endtask

	task automatic run_episode();
		logic [15:0] anchor;
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			// noise: anything anywhere
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 1) == 1)
					send_request(KIND_TICK, 16'($urandom));
				else
					send_request(KIND_SAMPLE, 16'($urandom));
			end
		end else begin
			anchor = (pick == 1) ? 16'($urandom) : thr_now[$urandom_range(0, 3)];
			repeat ($urandom_range(1, 3)) begin
				send_request(KIND_SAMPLE, anchor + 16'($urandom_range(0, 6)) - 16'd3);
				send_ticks($urandom_range(0, 25));
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_SAMPLE;
		burst_left     = $urandom_range(1, 40);
		for (int i = 0; i < 4; i++)
			thr_now[i] = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all thresholds tied at zero, zero delays: both over timers expire together
		send_request(KIND_SAMPLE, 16'h0000);
		send_request(KIND_SAMPLE, 16'hFFFF);
		send_ticks(10);
		send_request(KIND_TICK, 16'hFFFF);
		wait_idle();

		load_settings(16'd5000, 16'd5200, 16'd4800, 16'd4600,
		              16'd0, 16'd1, 16'd2, 16'hFFFF);
		send_request(KIND_SAMPLE, 16'd5000);
		send_request(KIND_SAMPLE, 16'd5201);
		send_request(KIND_SAMPLE, 16'd5100);
		send_request(KIND_SAMPLE, 16'd4599);
		send_request(KIND_SAMPLE, 16'd4700);
		send_ticks(10);
		wait_idle();

		while (items_sent < ITEM_GOAL) begin
			random_settings();
			phase_goal = items_sent + $urandom_range(80, 200);
			while (items_sent < phase_goal)
				run_episode();
			wait_idle();
		end

		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tsfp_pkg.sv
rtl/core/tsfp_timer.sv
rtl/core/two_stage_frequency_protection_top.sv
bench/trip_checker.sv
bench/tb_top.sv
